[src/space_vector_pwm_timing_assert.svh]
// Assertion macros shared by the SVPWM timing RTL
`ifndef SPACE_VECTOR_PWM_TIMING_ASSERT_SVH
`define SPACE_VECTOR_PWM_TIMING_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SVPWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked from the following cycle on
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/svpwm_pkg.sv]
// Package: types, widths, register map and sine ROM builder for the SVPWM timing block
package svpwm_pkg;

    localparam int SINE_ENTRIES = 1024;
    localparam int KW           = $clog2(SINE_ENTRIES + 1);
    localparam int SW           = 15;
    localparam int MG_W         = 32;
    localparam int T_W          = MG_W + SW - 21;
    localparam int D_W          = T_W + 3;
    localparam int P_W          = 16 + D_W - 1;
    localparam int APB_AW       = 3;

    localparam longint unsigned PI_OVER_3_Q30 = 64'd1124419809;
    localparam logic [15:0]     GAIN_RESET    = 16'd473;
    localparam logic [15:0]     PERIOD_RESET  = 16'd7500;
    localparam logic [D_W-1:0]  ONE_Q16       = D_W'(65536);

    typedef enum logic
    {
        REG_GAIN   = 1'b0,
        REG_PERIOD = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        SEC1 = 3'd1,
        SEC2 = 3'd2,
        SEC3 = 3'd3,
        SEC4 = 3'd4,
        SEC5 = 3'd5,
        SEC6 = 3'd6
    } sector_t;

    typedef struct packed
    {
        logic [15:0] magnitude;
        logic [15:0] angle;
    } item_t;

    typedef struct packed
    {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
        logic [2:0]  sector;
        logic        overmodulated;
    } result_t;

    typedef struct packed
    {
        logic [15:0] gain;
        logic [15:0] period;
    } cfg_t;

    typedef struct packed
    {
        logic            valid;
        logic [2:0]      sector;
        logic [MG_W-1:0] mg;
        logic [SW-1:0]   sin_a;
        logic [SW-1:0]   sin_b;
    } front_t;

    typedef struct packed
    {
        logic                  valid;
        logic [2:0]            sector;
        logic                  over;
        logic signed [D_W-1:0] d_a;
        logic signed [D_W-1:0] d_b;
        logic signed [D_W-1:0] d_c;
    } times_t;

    typedef logic [SW-1:0] sine_rom_t [0:SINE_ENTRIES];

    // sin(k*(pi/3)/N) in unsigned Q0.15 via Q30 Taylor series, elaboration only
    function automatic logic [SW-1:0] sine_q15(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (PI_OVER_3_Q30 * k + SINE_ENTRIES / 2) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        return SW'((sum + 16384) >>> 15);
    endfunction

    function automatic sine_rom_t sine_rom_build();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_ENTRIES; k++)
        begin
            rom[k] = sine_q15(64'(k));
        end
        return rom;
    endfunction

endpackage

[src/svpwm_cfg.sv]
// APB register file: modulation gain and PWM period
module svpwm_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [svpwm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output svpwm_pkg::cfg_t            cfg
);
    import svpwm_pkg::*;

    logic [15:0] gain_reg;
    logic [15:0] period_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_GAIN:   gain_reg   <= pwdata[15:0];
                REG_PERIOD: period_reg <= pwdata[15:0];
                default:    gain_reg   <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN:   prdata = {16'd0, gain_reg};
            REG_PERIOD: prdata = {16'd0, period_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.gain   = gain_reg;
    assign cfg.period = period_reg;

endmodule

[src/svpwm_front.sv]
// Front stages: sector split, table index, magnitude*gain, registered sine ROM reads
module svpwm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  svpwm_pkg::item_t   item,
    input  logic [15:0]        gain,
    output svpwm_pkg::front_t  front
);
    import svpwm_pkg::*;

    localparam sine_rom_t SINE_ROM = sine_rom_build();

    logic [18:0]      p_next;
    logic [16+KW-1:0] kprod_next;
    logic [KW-1:0]    kb_next;

    logic             v1_reg;
    logic [2:0]       sec1_reg;
    logic [MG_W-1:0]  mg1_reg;
    logic [KW-1:0]    ka1_reg;
    logic [KW-1:0]    kb1_reg;

    logic             v2_reg;
    logic [2:0]       sec2_reg;
    logic [MG_W-1:0]  mg2_reg;
    logic [SW-1:0]    sa2_reg;
    logic [SW-1:0]    sb2_reg;

    assign p_next     = {3'd0, item.angle} * 19'd6;
    assign kprod_next = {{KW{1'b0}}, p_next[15:0]} * (16 + KW)'(SINE_ENTRIES);
    assign kb_next    = kprod_next[16+KW-1:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sec1_reg <= p_next[18:16] + 3'd1;
        mg1_reg  <= {16'd0, item.magnitude} * {16'd0, gain};
        kb1_reg  <= kb_next;
        ka1_reg  <= KW'(SINE_ENTRIES) - kb_next;

        sec2_reg <= sec1_reg;
        mg2_reg  <= mg1_reg;
        sa2_reg  <= SINE_ROM[ka1_reg];
        sb2_reg  <= SINE_ROM[kb1_reg];
    end

    assign front.valid  = v2_reg;
    assign front.sector = sec2_reg;
    assign front.mg     = mg2_reg;
    assign front.sin_a  = sa2_reg;
    assign front.sin_b  = sb2_reg;

endmodule

[src/svpwm_times.sv]
// Active-time products and per-sector placement of the phase on-times
module svpwm_times
(
    input  logic               clk,
    input  logic               rst_n,
    input  svpwm_pkg::front_t  front,
    output svpwm_pkg::times_t  times
);
    import svpwm_pkg::*;

    logic [MG_W+SW-1:0]    pa_next;
    logic [MG_W+SW-1:0]    pb_next;

    logic                  v3_reg;
    logic [2:0]            sec3_reg;
    logic [T_W-1:0]        ta_reg;
    logic [T_W-1:0]        tb_reg;

    logic [D_W-1:0]        ts;
    logic signed [D_W-1:0] d_full;
    logic signed [D_W-1:0] d_none;
    logic signed [D_W-1:0] d_onlya;
    logic signed [D_W-1:0] d_onlyb;
    logic signed [D_W-1:0] da_next;
    logic signed [D_W-1:0] db_next;
    logic signed [D_W-1:0] dc_next;

    logic                  v4_reg;
    logic [2:0]            sec4_reg;
    logic                  over4_reg;
    logic signed [D_W-1:0] da4_reg;
    logic signed [D_W-1:0] db4_reg;
    logic signed [D_W-1:0] dc4_reg;

    assign pa_next = {{SW{1'b0}}, front.mg} * {{MG_W{1'b0}}, front.sin_a};
    assign pb_next = {{SW{1'b0}}, front.mg} * {{MG_W{1'b0}}, front.sin_b};

    // d = 2*one - doubled on-time, per phase role
    assign ts      = {3'd0, ta_reg} + {3'd0, tb_reg};
    assign d_full  = ONE_Q16 - ts;
    assign d_none  = ONE_Q16 + ts;
    assign d_onlya = ONE_Q16 - {3'd0, ta_reg} + {3'd0, tb_reg};
    assign d_onlyb = ONE_Q16 + {3'd0, ta_reg} - {3'd0, tb_reg};

    always_comb
    begin
        case (sector_t'(sec3_reg))
            SEC1:
            begin
                da_next = d_full;
                db_next = d_onlyb;
                dc_next = d_none;
            end
            SEC2:
            begin
                da_next = d_onlya;
                db_next = d_full;
                dc_next = d_none;
            end
            SEC3:
            begin
                da_next = d_none;
                db_next = d_full;
                dc_next = d_onlyb;
            end
            SEC4:
            begin
                da_next = d_none;
                db_next = d_onlya;
                dc_next = d_full;
            end
            SEC5:
            begin
                da_next = d_onlyb;
                db_next = d_none;
                dc_next = d_full;
            end
            default:
            begin
                da_next = d_full;
                db_next = d_none;
                dc_next = d_onlya;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= front.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sec3_reg  <= front.sector;
        ta_reg    <= pa_next[MG_W+SW-1:21];
        tb_reg    <= pb_next[MG_W+SW-1:21];

        sec4_reg  <= sec3_reg;
        over4_reg <= ts > ONE_Q16;
        da4_reg   <= da_next;
        db4_reg   <= db_next;
        dc4_reg   <= dc_next;
    end

    assign times.valid  = v4_reg;
    assign times.sector = sec4_reg;
    assign times.over   = over4_reg;
    assign times.d_a    = da4_reg;
    assign times.d_b    = db4_reg;
    assign times.d_c    = dc4_reg;

endmodule

[src/svpwm_cmp.sv]
// Compare value scaling by the PWM period and clamping
`include "space_vector_pwm_timing_assert.svh"

module svpwm_cmp
(
    input  logic               clk,
    input  logic               rst_n,
    input  svpwm_pkg::times_t  times,
    input  logic [15:0]        period,
    output logic               done,
    output svpwm_pkg::result_t result
);
    import svpwm_pkg::*;

    logic             v5_reg;
    logic [2:0]       sec5_reg;
    logic             over5_reg;
    logic [2:0]       pos5_reg;
    logic [P_W-1:0]   na5_reg;
    logic [P_W-1:0]   nb5_reg;
    logic [P_W-1:0]   nc5_reg;

    logic [15:0]      ca_next;
    logic [15:0]      cb_next;
    logic [15:0]      cc_next;

    logic             v6_reg;
    result_t          res6_reg;

    function automatic logic [15:0] clamp_cmp(input logic pos, input logic [P_W-1:0] num,
                                              input logic [15:0] lim);
        logic [P_W-18:0] q;
        q = num[P_W-1:17];
        if (!pos)
        begin
            return 16'd0;
        end
        else if (q > {{(P_W-33){1'b0}}, lim})
        begin
            return lim;
        end
        return q[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= times.valid;
            v6_reg <= v5_reg;
        end
    end

    assign ca_next = clamp_cmp(pos5_reg[0], na5_reg, period);
    assign cb_next = clamp_cmp(pos5_reg[1], nb5_reg, period);
    assign cc_next = clamp_cmp(pos5_reg[2], nc5_reg, period);

    always_ff @(posedge clk)
    begin
        sec5_reg  <= times.sector;
        over5_reg <= times.over;
        pos5_reg  <= {times.d_c > 0, times.d_b > 0, times.d_a > 0};
        na5_reg   <= {{(D_W-1){1'b0}}, period} * {16'd0, times.d_a[D_W-2:0]};
        nb5_reg   <= {{(D_W-1){1'b0}}, period} * {16'd0, times.d_b[D_W-2:0]};
        nc5_reg   <= {{(D_W-1){1'b0}}, period} * {16'd0, times.d_c[D_W-2:0]};

        res6_reg.compare_a     <= ca_next;
        res6_reg.compare_b     <= cb_next;
        res6_reg.compare_c     <= cc_next;
        res6_reg.sector        <= sec5_reg;
        res6_reg.overmodulated <= over5_reg;
    end

    assign done   = v6_reg;
    assign result = res6_reg;

    `SVPWM_ASSERT_SAME(a_cmp_clamped, done, (result.compare_a <= period) && (result.compare_b <= period) && (result.compare_c <= period), "compare value above period")
    `SVPWM_ASSERT_NEXT(a_cmp_follows, v5_reg, done, "valid lost between last two stages")

endmodule

[src/space_vector_pwm_timing.sv]
// Top level: space-vector PWM timing, six-stage pipeline with APB configuration
//
//  channel   direction  handshake                    payload
//  input     in         start && !busy               item   (item_t)
//  result    out        done, one cycle, no backoff  result (result_t)
//  config    in/out     APB psel/penable/pwrite      paddr, pwdata, prdata
//
// One item per clock; done is the valid bit of the last stage register.
// Stages: magnitude*gain with sector split, registered sine ROM, magnitude*sine,
// per-sector placement, period scaling multiply, clamp.
// busy is always low; the pipeline never stalls and the receiver cannot stall.
// rst_n clears valid bits and loads config registers with reset values; no clearing pass.
`include "space_vector_pwm_timing_assert.svh"

module space_vector_pwm_timing
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  svpwm_pkg::item_t             item,
    output logic                         done,
    output svpwm_pkg::result_t           result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [svpwm_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import svpwm_pkg::*;

    cfg_t   cfg;
    front_t front;
    times_t times;
    logic   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    svpwm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svpwm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .item     (item),
        .gain     (cfg.gain),
        .front    (front)
    );

    svpwm_times u_times
    (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .times (times)
    );

    svpwm_cmp u_cmp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .times  (times),
        .period (cfg.period),
        .done   (done),
        .result (result)
    );

    `SVPWM_ASSERT_NEXT(a_latency, accept, ##5 done, "result not six cycles after transfer")
    `SVPWM_ASSERT_SAME(a_sector_range, done, (result.sector != 3'd0) && (result.sector != 3'd7), "sector out of range")

endmodule
